// ===== rtl/core/ibt_pkg.sv =====
// Shared types and constants for the interval booking table.
package ibt_pkg;

  localparam int unsigned TIME_W       = 32;
  localparam int unsigned USED_W       = 7;
  localparam int unsigned CAPACITY_DEF = 64;

  // Result status codes
  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Control states
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_DECIDE = 1'b1
  } state_e;

  // Booking request transaction
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } req_t;

  // Booking result transaction
  typedef struct packed {
    logic [1:0]        status;
    logic [USED_W-1:0] entries_used;
  } rsp_t;

  // One stored interval as it moves along the cell chain
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } entry_t;

endpackage

// ===== rtl/core/ibt_cell.sv =====
// One storage cell of the booking chain: holds an interval and checks overlap.
module ibt_cell
  import ibt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  input  logic   cmp_i,
  input  req_t   req_i,
  output entry_t entry_o,
  output logic   clash_o
);

  logic              valid_q;
  logic [TIME_W-1:0] start_q;
  logic [TIME_W-1:0] end_q;
  logic              clash_q;
  logic              clash_d;

  // Compare the stored interval against the incoming request
  assign clash_d = valid_q && (start_q < req_i.end_time) && (end_q > req_i.start_time);

  // Hold valid; take the neighbor's valid on a shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  // Advance the interval payload on a shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      start_q <= entry_i.start_time;
      end_q   <= entry_i.end_time;
    end
  end

  // Capture the overlap flag when a request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clash_q <= 1'b0;
    end else if (cmp_i) begin
      clash_q <= clash_d;
    end
  end

  assign entry_o = '{valid: valid_q, start_time: start_q, end_time: end_q};
  assign clash_o = clash_q;

endmodule

// ===== rtl/core/interval_booking_table.sv =====
// Interval booking table: a chain of cells that stores non-overlapping intervals.
// A taken request enters the decide state, which registers its one-cycle result strobe.
// No request is taken while one is deciding; busy is high for the single decide cycle.
// Every cell compares against the request as it is taken; the decide cycle ORs the flags.
// Reset clears the FSM, valid bits and count at once; interval payloads are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module interval_booking_table
  import ibt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e          state_q, state_d;
  logic            accept;
  logic            decide;
  req_t            req_q;
  logic            invalid_q;
  logic [CW-1:0]   used_q, used_d;
  logic            valid_q;
  rsp_t            rsp_q, rsp_d;
  status_e         status;
  logic            book;
  logic            clash_any;
  logic            full;

  entry_t              chain [CAPACITY+1];
  logic [CAPACITY-1:0] clash_vec;
  logic [CAPACITY-1:0] valid_vec;

  assign accept = start && !busy;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_DECIDE;
      S_DECIDE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // State-decoded outputs
  always_comb begin
    busy   = 1'b0;
    decide = 1'b0;
    case (state_q)
      S_IDLE:   busy = 1'b0;
      S_DECIDE: begin
        busy   = 1'b1;
        decide = 1'b1;
      end
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the request for the insert
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_i;
      invalid_q <= (req_i.start_time >= req_i.end_time);
    end
  end

  // Feed the head of the chain with the held request
  assign chain[0] = '{valid: 1'b1, start_time: req_q.start_time, end_time: req_q.end_time};

  // Build the cell chain; a booking shifts every entry one cell down
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ibt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (book),
      .entry_i (chain[g]),
      .cmp_i   (accept),
      .req_i   (req_i),
      .entry_o (chain[g+1]),
      .clash_o (clash_vec[g])
    );
    assign valid_vec[g] = chain[g+1].valid;
  end

  // Decide the status from the captured flags
  assign clash_any = |clash_vec;
  assign full      = valid_vec[CAPACITY-1];

  always_comb begin
    if (invalid_q) begin
      status = ST_INVALID;
    end else if (clash_any) begin
      status = ST_OVERLAP;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status = ST_BOOKED;
    end
  end

  assign book   = decide && (status == ST_BOOKED);
  assign used_d = book ? used_q + CW'(1) : used_q;

  always_comb begin
    rsp_d.status       = status;
    rsp_d.entries_used = USED_W'(used_d);
  end

  // Count stored intervals and raise the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      used_q  <= used_d;
      valid_q <= decide;
    end
  end

  // Register the result payload
  always_ff @(posedge clk_i) begin
    if (decide) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // The count always matches the occupied cells
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == CW'($countones(valid_vec)))
    else $error("used count differs from occupied cells");

  // A taken request is decided in the next cycle
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DECIDE))
    else $error("request not decided after accept");

  // A result strobe follows every decide cycle
  a_strobe_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decide |=> valid_o)
    else $error("missing result strobe");

  // Occupied cells stay packed from the head of the chain
  a_packed_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(valid_vec ^ (valid_vec >> 1)) && (valid_vec[0] || (valid_vec == '0)))
    else $error("occupied cells not contiguous");

  // A booking grows the count by exactly one
  a_book_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    book |=> (used_q == $past(used_q) + CW'(1)))
    else $error("booking did not advance count");

endmodule

// ===== tb/tb_interval_booking_table.sv =====
// Self-checking testbench for the interval booking table.
`timescale 1ns / 1ps

module tb_interval_booking_table;
  import ibt_pkg::*;

  localparam int unsigned CAPACITY  = CAPACITY_DEF;
  localparam int unsigned N_RANDOM  = 650;
  localparam logic [TIME_W-1:0] T_MAX = '1;
  localparam logic [TIME_W-1:0] WINDOW_BASE = 32'h0001_0000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic valid_o;
  rsp_t rsp_o;

  // Shadow of the booking table
  logic [TIME_W-1:0] held_start [CAPACITY];
  logic [TIME_W-1:0] held_end   [CAPACITY];
  bit                held_valid [CAPACITY];
  int unsigned       held_count = 0;

  req_t requests[$];
  rsp_t outcomes[$];

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned mismatches = 0;
  int unsigned status_seen [4];
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  interval_booking_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  // Decide one request against the shadow table and update it
  function automatic rsp_t decide_booking(req_t rq);
    rsp_t res;
    logic clash;
    int   free_slot;
    clash     = 1'b0;
    free_slot = -1;
    if (rq.start_time >= rq.end_time) begin
      res.status = ST_INVALID;
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (held_valid[i]) begin
          if (held_start[i] < rq.end_time && held_end[i] > rq.start_time) clash = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (clash) begin
        res.status = ST_OVERLAP;
      end else if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        held_start[free_slot] = rq.start_time;
        held_end[free_slot]   = rq.end_time;
        held_valid[free_slot] = 1'b1;
        held_count++;
        res.status = ST_BOOKED;
      end
    end
    res.entries_used = held_count[USED_W-1:0];
    return res;
  endfunction

  task automatic queue_request(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e);
    req_t rq;
    rq.start_time = s;
    rq.end_time   = e;
    requests.push_back(rq);
    n_queued++;
  endtask

  // Driver: present queued requests in bursts, predict each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        outcomes.push_back(decide_booking(req_i));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (requests.size() > 0) begin
          req_i <= requests.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result strobe against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (outcomes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d used %0d",
                 $time, rsp_o.status, rsp_o.entries_used);
        mismatches++;
      end else begin
        rsp_t want;
        want = outcomes.pop_front();
        n_checked++;
        status_seen[want.status]++;
        if (rsp_o.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, rsp_o.status);
          mismatches++;
        end
        if (rsp_o.entries_used !== want.entries_used) begin
          $display("%0t: entries_used mismatch: expected %0d, actual %0d",
                   $time, want.entries_used, rsp_o.entries_used);
          mismatches++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [TIME_W-1:0] s, e, len;
    int unsigned pick, k;

    // Extremes, empty and reversed intervals, touching and overlapping cases
    queue_request(32'd0, 32'd1);
    queue_request(32'd0, 32'd0);
    queue_request(32'd7, 32'd3);
    queue_request(T_MAX, T_MAX);
    queue_request(T_MAX, 32'd0);
    queue_request(T_MAX - 1, T_MAX);
    queue_request(32'd0, T_MAX);
    queue_request(32'd1, 32'd10);
    queue_request(32'd10, 32'd20);
    queue_request(32'd5, 32'd15);
    queue_request(32'd19, 32'd20);
    queue_request(32'd0, 32'd30);
    queue_request(32'd20, 32'd21);
    queue_request(32'd25, 32'd26);
    queue_request(32'd21, 32'd25);
    queue_request(T_MAX - 15, T_MAX - 1);
    queue_request(T_MAX - 10, T_MAX);
    queue_request(32'h8000_0000, 32'h8000_0001);
    queue_request(32'h7FFF_FFFF, 32'h8000_0001);
    queue_request(32'h5555_5555, 32'hAAAA_AAAA);
    queue_request(32'hAAAA_AAAA, 32'hAAAA_AAAB);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random requests, shaped from the current table contents
    for (int n = 0; n < N_RANDOM; n++) begin
      while (requests.size() >= 2) @(posedge clk_i);
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, CAPACITY - 1);
      len  = $urandom_range(1, 64);
      if (pick < 15) begin
        // empty or reversed interval over the full range
        s = $urandom;
        e = ($urandom_range(0, 3) == 0) ? s : $urandom_range(0, s);
      end else if (pick < 35) begin
        // narrow interval anywhere
        s = $urandom;
        if (s > T_MAX - len) s = T_MAX - len;
        e = s + len;
      end else if (pick < 60 || !held_valid[k]) begin
        // crowded window that fills up
        s = WINDOW_BASE + $urandom_range(0, 2047);
        e = s + $urandom_range(1, 48);
      end else if (pick < 80) begin
        // touch a stored interval on one side
        if (held_end[k] <= T_MAX - len && $urandom_range(0, 1) == 1) begin
          s = held_end[k];
          e = s + len;
        end else begin
          e = held_start[k];
          s = (e > len) ? e - len : 32'd0;
        end
      end else begin
        // overlap a stored interval
        s = held_start[k] + $urandom_range(0, held_end[k] - held_start[k] - 1);
        e = (s > T_MAX - len) ? T_MAX : s + len;
      end
      queue_request(s, e);
    end

    // Drain
    while (n_accepted != n_queued || outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);

    $display("covered %0d requests: %0d booked, %0d overlapping, %0d full, %0d invalid",
             n_checked, status_seen[ST_BOOKED], status_seen[ST_OVERLAP],
             status_seen[ST_FULL], status_seen[ST_INVALID]);
    $display("table holds %0d of %0d entries, %0d mismatches", held_count, CAPACITY,
             mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("timeout: %0d of %0d requests accepted, %0d results outstanding",
             n_accepted, n_queued, outcomes.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
